### rtl/assert_macros.svh
// Assertion macros for the checker file of this block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, masked while reset is held
`define CHK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("checker assertion failed");

// Plain invariant, also masked during reset
`define CHK_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("checker invariant broken");

`endif

### rtl/lfsa_pkg.sv
// Package: widths, limits and sequencer states of the seat allocator
`timescale 1ns / 1ps
`default_nettype none

package lfsa_pkg;

    localparam int SEATS_DEF = 32;
    localparam int TIME_W    = 32;
    localparam int SEAT_W    = 5;
    localparam int USE_W     = 16;
    localparam int PEAK_W    = 6;

    localparam logic [USE_W-1:0]  USE_MAX  = '1;
    localparam logic [PEAK_W-1:0] PEAK_MAX = '1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_OUT
    } t_state;

endpackage

`default_nettype wire

### rtl/lfsa_ram.sv
// Generic single-write, single-read RAM with registered read data
`timescale 1ns / 1ps
`default_nettype none

module lfsa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

### rtl/lowest_free_seat_allocator.sv
// Top level: lowest-free seat allocator with a one-seat-per-cycle sequencer
`timescale 1ns / 1ps
`default_nettype none

// Books each request onto the lowest-numbered free seat. Requests should
// arrive in nondecreasing start order. One beat in gives one beat out: the
// seat, its new (saturating) use count and the peak number of busy seats so
// far, or no_seat_free with all other fields zero when every seat stays busy.
// The block works on one request at a time and drops o_ready meanwhile.
// o_valid rises once the scan, drain, decide and update steps are done (the
// update step is skipped for a refusal), and the next request is taken back
// in idle once the result beat has been accepted. The scan pass reads one
// stored end time per cycle from the end-time memory and runs it through a
// single compare that releases the seat, counts it as busy or picks it as
// the lowest free one. End times and use counts live in memories; busy and
// use-count valid bits are flip-flops cleared at reset, so no clearing pass
// is needed.
module lowest_free_seat_allocator
    import lfsa_pkg::*;
#(
    parameter int SEATS = SEATS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire logic [TIME_W-1:0] i_start_time,
    input  wire logic [TIME_W-1:0] i_end_time,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output logic      [SEAT_W-1:0] o_seat,
    output logic      [USE_W-1:0]  o_seat_uses,
    output logic      [PEAK_W-1:0] o_peak_busy,
    output logic                   o_no_seat_free
);

    localparam int IDX_W   = $clog2(SEATS);
    localparam int CNT_W   = $clog2(SEATS + 1);
    localparam int WIDE_W  = (CNT_W > PEAK_W) ? CNT_W : PEAK_W;
    localparam int SEATX_W = (IDX_W > SEAT_W) ? IDX_W : SEAT_W;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEATS - 1);

    // control state
    t_state            r_state, n_state;
    logic [SEATS-1:0]  r_busy, n_busy;
    logic [SEATS-1:0]  r_used, n_used;
    logic [PEAK_W-1:0] r_peak, n_peak;
    logic              r_chk_on, n_chk_on;
    logic              r_pick_found, n_pick_found;

    // payload registers
    logic [TIME_W-1:0] r_start, n_start;
    logic [TIME_W-1:0] r_end, n_end;
    logic [IDX_W-1:0]  r_cnt, n_cnt;
    logic [IDX_W-1:0]  r_chk_idx, n_chk_idx;
    logic [IDX_W-1:0]  r_pick, n_pick;
    logic [CNT_W-1:0]  r_busy_n, n_busy_n;
    logic [SEAT_W-1:0] r_o_seat, n_o_seat;
    logic [USE_W-1:0]  r_o_uses, n_o_uses;
    logic [PEAK_W-1:0] r_o_peak, n_o_peak;
    logic              r_o_nofree, n_o_nofree;

    // memory ports
    logic              et_we;
    logic [TIME_W-1:0] et_rdata;
    logic              uc_we;
    logic [USE_W-1:0]  uc_rdata;

    // datapath helpers
    logic              seat_was_busy;
    logic              seat_release;
    logic [USE_W-1:0]  uses_old;
    logic [USE_W-1:0]  uses_new;
    logic [CNT_W-1:0]  busy_tot;
    logic [WIDE_W-1:0] busy_wide;
    logic [PEAK_W-1:0] busy_sat;
    logic [SEATX_W-1:0] pick_ext;

    // end time per seat, read once per seat during the scan
    lfsa_ram #(
        .WIDTH (TIME_W),
        .DEPTH (SEATS)
    ) u_end_ram (
        .i_clk   (i_clk),
        .i_we    (et_we),
        .i_waddr (r_pick),
        .i_wdata (r_end),
        .i_raddr (r_cnt),
        .o_rdata (et_rdata)
    );

    // use count per seat, read at the picked seat
    lfsa_ram #(
        .WIDTH (USE_W),
        .DEPTH (SEATS)
    ) u_use_ram (
        .i_clk   (i_clk),
        .i_we    (uc_we),
        .i_waddr (r_pick),
        .i_wdata (uses_new),
        .i_raddr (r_pick),
        .o_rdata (uc_rdata)
    );

    // seat update arithmetic: saturating use count and saturating busy total
    always_comb begin
        uses_old  = r_used[r_pick] ? uc_rdata : '0;
        uses_new  = (uses_old == USE_MAX) ? uses_old : USE_W'(uses_old + 1'b1);
        busy_tot  = CNT_W'(r_busy_n + 1'b1);
        busy_wide = WIDE_W'(busy_tot);
        busy_sat  = (busy_wide > WIDE_W'(PEAK_MAX)) ? PEAK_MAX : busy_wide[PEAK_W-1:0];
        pick_ext  = SEATX_W'(r_pick);
    end

    // sequencer: next state, scan check and result load
    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_used       = r_used;
        n_peak       = r_peak;
        n_chk_on     = 1'b0;
        n_pick_found = r_pick_found;
        n_start      = r_start;
        n_end        = r_end;
        n_cnt        = r_cnt;
        n_chk_idx    = r_chk_idx;
        n_pick       = r_pick;
        n_busy_n     = r_busy_n;
        n_o_seat     = r_o_seat;
        n_o_uses     = r_o_uses;
        n_o_peak     = r_o_peak;
        n_o_nofree   = r_o_nofree;
        et_we        = 1'b0;
        uc_we        = 1'b0;
        o_ready      = 1'b0;
        o_valid      = 1'b0;

        // check stage: release, then count as busy or take as lowest free
        seat_was_busy = r_busy[r_chk_idx];
        seat_release  = seat_was_busy && (et_rdata <= r_start);
        if (r_chk_on) begin
            if (seat_release) begin
                n_busy[r_chk_idx] = 1'b0;
            end
            if (seat_was_busy && !seat_release) begin
                n_busy_n = CNT_W'(r_busy_n + 1'b1);
            end else if (!r_pick_found) begin
                n_pick       = r_chk_idx;
                n_pick_found = 1'b1;
            end
        end

        unique case (r_state)
            ST_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_start      = i_start_time;
                    n_end        = i_end_time;
                    n_cnt        = '0;
                    n_pick_found = 1'b0;
                    n_busy_n     = '0;
                    n_state      = ST_SCAN;
                end
            end
            ST_SCAN: begin
                n_chk_on  = 1'b1;
                n_chk_idx = r_cnt;
                if (r_cnt == LAST_IDX) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = IDX_W'(r_cnt + 1'b1);
                end
            end
            ST_DRAIN: begin
                n_state = ST_DECIDE;
            end
            ST_DECIDE: begin
                // use-count read at the pick is issued here
                if (r_pick_found) begin
                    n_state = ST_UPDATE;
                end else begin
                    n_o_seat   = '0;
                    n_o_uses   = '0;
                    n_o_peak   = '0;
                    n_o_nofree = 1'b1;
                    n_state    = ST_OUT;
                end
            end
            ST_UPDATE: begin
                et_we          = 1'b1;
                uc_we          = 1'b1;
                n_busy[r_pick] = 1'b1;
                n_used[r_pick] = 1'b1;
                n_peak         = (busy_sat > r_peak) ? busy_sat : r_peak;
                n_o_seat       = pick_ext[SEAT_W-1:0];
                n_o_uses       = uses_new;
                n_o_peak       = (busy_sat > r_peak) ? busy_sat : r_peak;
                n_o_nofree     = 1'b0;
                n_state        = ST_OUT;
            end
            ST_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_busy       <= '0;
            r_used       <= '0;
            r_peak       <= '0;
            r_chk_on     <= 1'b0;
            r_pick_found <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_busy       <= n_busy;
            r_used       <= n_used;
            r_peak       <= n_peak;
            r_chk_on     <= n_chk_on;
            r_pick_found <= n_pick_found;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_start    <= n_start;
        r_end      <= n_end;
        r_cnt      <= n_cnt;
        r_chk_idx  <= n_chk_idx;
        r_pick     <= n_pick;
        r_busy_n   <= n_busy_n;
        r_o_seat   <= n_o_seat;
        r_o_uses   <= n_o_uses;
        r_o_peak   <= n_o_peak;
        r_o_nofree <= n_o_nofree;
    end

    assign o_seat         = r_o_seat;
    assign o_seat_uses    = r_o_uses;
    assign o_peak_busy    = r_o_peak;
    assign o_no_seat_free = r_o_nofree;

endmodule

`default_nettype wire

### rtl/lfsa_chk.sv
// Port-level checker for the seat allocator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module lfsa_chk
    import lfsa_pkg::*;
(
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_valid,
    input wire logic              o_ready,
    input wire logic              o_valid,
    input wire logic              i_ready,
    input wire logic [SEAT_W-1:0] o_seat,
    input wire logic [USE_W-1:0]  o_seat_uses,
    input wire logic [PEAK_W-1:0] o_peak_busy,
    input wire logic              o_no_seat_free
);

    // one request at a time: never taking a beat while a result is shown
    `CHK_NEVER(a_ready_xor_valid, i_clk, i_rst_n, o_ready && o_valid)

    // an accepted beat closes the input side on the next cycle
    `CHK_ASSERT(a_busy_after_take, i_clk, i_rst_n, (i_valid && o_ready) |=> !o_ready)

    // refused request carries zeros in every other field
    `CHK_ASSERT(a_refuse_zero, i_clk, i_rst_n, (o_valid && o_no_seat_free) |-> (o_seat == '0 && o_seat_uses == '0 && o_peak_busy == '0))

    // a granted seat has been used at least once and something is busy
    `CHK_ASSERT(a_grant_nonzero, i_clk, i_rst_n, (o_valid && !o_no_seat_free) |-> (o_seat_uses != '0 && o_peak_busy != '0))

    // a result stays up until it is taken
    `CHK_ASSERT(a_result_holds, i_clk, i_rst_n, (o_valid && !i_ready) |=> o_valid)

endmodule

bind lowest_free_seat_allocator lfsa_chk u_lfsa_chk (.*);

`default_nettype wire
